>>> src/matrix3_inverse_macros.svh
// assertion helpers shared by mi3_queue and mi3_back
`ifndef MATRIX3_INVERSE_MACROS_SVH
`define MATRIX3_INVERSE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MI3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition holds at every edge out of reset
`define MI3_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	`MI3_ASSERT_IMP(label, clk, rst_n, 1'b1, cond)

`endif

>>> src/mi3_pkg.sv
`default_nettype none
package mi3_pkg;
	localparam int N_ELEM = 9;
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// element indexes per cofactor: a*b - c*d
	localparam logic [3:0] CF_IDX [N_ELEM][4] = '{
		'{4'd4, 4'd8, 4'd5, 4'd7},
		'{4'd5, 4'd6, 4'd3, 4'd8},
		'{4'd3, 4'd7, 4'd4, 4'd6},
		'{4'd2, 4'd7, 4'd1, 4'd8},
		'{4'd0, 4'd8, 4'd2, 4'd6},
		'{4'd1, 4'd6, 4'd0, 4'd7},
		'{4'd1, 4'd5, 4'd2, 4'd4},
		'{4'd2, 4'd3, 4'd0, 4'd5},
		'{4'd0, 4'd4, 4'd1, 4'd3}
	};

	typedef struct packed {
		logic push;
		logic pop;
	} q_evt_t;
endpackage
`default_nettype wire

>>> src/mi3_front.sv
`default_nettype none
module mi3_front import mi3_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((N_ELEM*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic q_pop,
	output logic push,
	output logic [N_ELEM*(2*DATA_WIDTH+1)-1:0] cof,
	output logic [3*DATA_WIDTH+2:0] det
);
	localparam int W = DATA_WIDTH;
	localparam int CW = 2*W + 1;
	localparam int PW = 2*W + 1;
	localparam int DW = 3*W + 3;

	logic [QCNT_W-1:0] cnt_q;
	logic acc;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [W-1:0] e_s1 [N_ELEM];
	logic signed [2*W-1:0] pa_s2 [N_ELEM];
	logic signed [2*W-1:0] pb_s2 [N_ELEM];
	logic signed [W-1:0] e0_s2 [3];
	logic signed [W-1:0] e0_s3 [3];
	logic signed [CW-1:0] cf_s3 [N_ELEM];
	logic signed [CW-1:0] cf_s4 [N_ELEM];
	logic signed [CW-1:0] cf_s5 [N_ELEM];
	logic signed [CW-1:0] cf_s6 [N_ELEM];
	logic signed [PW-1:0] plo_s4 [3];
	logic signed [PW-1:0] phi_s4 [3];
	logic signed [DW-1:0] pr_s5 [3];
	logic signed [DW-1:0] d_s6;

	assign s_tready = cnt_q < QCNT_W'(QUEUE_DEPTH);
	assign acc = s_tvalid && s_tready;

	// items accepted and not yet taken out of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({acc, q_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N_ELEM; i++) begin
			e_s1[i] <= s_tdata[i*W +: W];
			pa_s2[i] <= e_s1[CF_IDX[i][0]] * e_s1[CF_IDX[i][1]];
			pb_s2[i] <= e_s1[CF_IDX[i][2]] * e_s1[CF_IDX[i][3]];
			cf_s3[i] <= CW'(pa_s2[i]) - CW'(pb_s2[i]);
			cf_s4[i] <= cf_s3[i];
			cf_s5[i] <= cf_s4[i];
			cf_s6[i] <= cf_s5[i];
		end
		for (int j = 0; j < 3; j++) begin
			e0_s2[j] <= e_s1[j];
			e0_s3[j] <= e0_s2[j];
			// row 0 times cofactor, split into low and high halves of the cofactor
			plo_s4[j] <= e0_s3[j] * $signed({1'b0, cf_s3[j][W-1:0]});
			phi_s4[j] <= e0_s3[j] * $signed(cf_s3[j][CW-1:W]);
			pr_s5[j] <= (DW'(phi_s4[j]) <<< W) + DW'(plo_s4[j]);
		end
		d_s6 <= pr_s5[0] + pr_s5[1] + pr_s5[2];
	end

	assign push = v_s6;
	assign det = d_s6;
	always_comb begin
		for (int i = 0; i < N_ELEM; i++) begin
			cof[i*CW +: CW] = cf_s6[i];
		end
	end
endmodule
`default_nettype wire

>>> src/mi3_queue.sv
`default_nettype none
`include "matrix3_inverse_macros.svh"
module mi3_queue import mi3_pkg::*; #(
	parameter int DATA_W = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  q_evt_t evt,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata,
	output logic not_empty
);
	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (evt.push) wp_q <= wp_q + 1'b1;
			if (evt.pop) rp_q <= rp_q + 1'b1;
			case ({evt.push, evt.pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (evt.push) mem_q[wp_q] <= wdata;
	end

	assign rdata = mem_q[rp_q];
	assign not_empty = cnt_q != '0;

	`MI3_ASSERT_IMP(a_no_overrun, clk, arst_n, evt.push && !evt.pop, cnt_q < QCNT_W'(QUEUE_DEPTH))
	`MI3_ASSERT_IMP(a_no_underrun, clk, arst_n, evt.pop, cnt_q != '0)
	`MI3_ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= QCNT_W'(QUEUE_DEPTH))
endmodule
`default_nettype wire

>>> src/mi3_back.sv
`default_nettype none
`include "matrix3_inverse_macros.svh"
module mi3_back import mi3_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  logic [N_ELEM*(2*DATA_WIDTH+1)-1:0] q_cof,
	input  logic [3*DATA_WIDTH+2:0] q_det,
	output logic q_pop,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((10*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic [1:0] m_tuser
);
	localparam int W = DATA_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int CW = 2*W + 1;
	localparam int DW = 3*W + 3;
	localparam int XW = (CW + 2*F > DW + W) ? CW + 2*F : DW + W;
	localparam int MW = ((10*W + 7)/8)*8;

	logic en;
	logic vo_q;

	// abs stage
	logic v_s1;
	logic [CW-1:0] cm_s1 [N_ELEM];
	logic cn_s1 [N_ELEM];
	logic [DW-1:0] dm_s1;
	logic dn_s1, sing_s1, dov_s1;
	logic [W-1:0] det_s1;

	// divider stages, index 0 is the setup stage
	logic dv_v_s [W+1];
	logic [DW-1:0] dv_dm_s [W+1];
	logic dv_sing_s [W+1];
	logic dv_dov_s [W+1];
	logic [W-1:0] dv_det_s [W+1];
	logic [DW-1:0] dv_rem_s [W+1][N_ELEM];
	logic [W-1:0] dv_low_s [W+1][N_ELEM];
	logic [W-1:0] dv_q_s [W+1][N_ELEM];
	logic dv_neg_s [W+1][N_ELEM];
	logic dv_big_s [W+1][N_ELEM];

	logic [W-1:0] inv_q [N_ELEM];
	logic [W-1:0] det_q;
	logic sing_q, ovf_q;

	logic signed [DW-1:0] dsh;
	logic [DW-W:0] dhi;
	logic [CW-1:0] cf_lane [N_ELEM];
	logic [DW-1:0] rem_n [W][N_ELEM];
	logic ge_n [W][N_ELEM];
	logic [XW-1:0] nn [N_ELEM];
	logic [XW-1:0] dd;
	logic [W-1:0] val_n [N_ELEM];
	logic sat_n [N_ELEM];
	logic ovf_n;

	assign en = !vo_q || m_tready;
	assign q_pop = en && q_valid;

	assign dsh = $signed(q_det) >>> (2*F);
	assign dhi = dsh[DW-1:W-1];

	always_comb begin
		// transpose: output (r,c) takes cofactor (c,r)
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				cf_lane[r*3+c] = q_cof[(c*3+r)*CW +: CW];
			end
		end
		for (int i = 0; i < N_ELEM; i++) begin
			nn[i] = XW'(cm_s1[i]) << (2*F);
		end
		dd = XW'(dm_s1) << W;
		for (int k = 0; k < W; k++) begin
			for (int i = 0; i < N_ELEM; i++) begin
				ge_n[k][i] = {dv_rem_s[k][i], dv_low_s[k][i][W-1]} >= {1'b0, dv_dm_s[k]};
				rem_n[k][i] = ge_n[k][i]
					? DW'({dv_rem_s[k][i], dv_low_s[k][i][W-1]} - {1'b0, dv_dm_s[k]})
					: DW'({dv_rem_s[k][i], dv_low_s[k][i][W-1]});
			end
		end
		ovf_n = dv_dov_s[W];
		for (int i = 0; i < N_ELEM; i++) begin
			if (dv_neg_s[W][i]) begin
				sat_n[i] = dv_big_s[W][i] || (dv_q_s[W][i] > {1'b1, {(W-1){1'b0}}});
				val_n[i] = sat_n[i] ? {1'b1, {(W-1){1'b0}}} : (~dv_q_s[W][i] + 1'b1);
			end else begin
				sat_n[i] = dv_big_s[W][i] || dv_q_s[W][i][W-1];
				val_n[i] = sat_n[i] ? {1'b0, {(W-1){1'b1}}} : dv_q_s[W][i];
			end
			if (dv_sing_s[W]) begin
				sat_n[i] = 1'b0;
				val_n[i] = '0;
			end
			ovf_n = ovf_n | sat_n[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vo_q <= 1'b0;
			for (int k = 0; k <= W; k++) dv_v_s[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= q_pop;
			dv_v_s[0] <= v_s1;
			for (int k = 0; k < W; k++) dv_v_s[k+1] <= dv_v_s[k];
			vo_q <= dv_v_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_ELEM; i++) begin
				cn_s1[i] <= cf_lane[i][CW-1];
				cm_s1[i] <= cf_lane[i][CW-1] ? (~cf_lane[i] + 1'b1) : cf_lane[i];
			end
			dn_s1 <= q_det[DW-1];
			dm_s1 <= q_det[DW-1] ? (~q_det + 1'b1) : q_det;
			sing_s1 <= q_det == '0;
			dov_s1 <= !((&dhi) || !(|dhi));
			det_s1 <= ((&dhi) || !(|dhi)) ? dsh[W-1:0] : {dhi[DW-W], {(W-1){~dhi[DW-W]}}};

			// setup: quotient overflow test and leading remainder
			dv_dm_s[0] <= dm_s1;
			dv_sing_s[0] <= sing_s1;
			dv_dov_s[0] <= dov_s1;
			dv_det_s[0] <= det_s1;
			for (int i = 0; i < N_ELEM; i++) begin
				dv_big_s[0][i] <= nn[i] >= dd;
				dv_rem_s[0][i] <= DW'(nn[i] >> W);
				dv_low_s[0][i] <= nn[i][W-1:0];
				dv_q_s[0][i] <= '0;
				dv_neg_s[0][i] <= cn_s1[i] ^ dn_s1;
			end

			// one quotient bit per stage
			for (int k = 0; k < W; k++) begin
				dv_dm_s[k+1] <= dv_dm_s[k];
				dv_sing_s[k+1] <= dv_sing_s[k];
				dv_dov_s[k+1] <= dv_dov_s[k];
				dv_det_s[k+1] <= dv_det_s[k];
				for (int i = 0; i < N_ELEM; i++) begin
					dv_rem_s[k+1][i] <= rem_n[k][i];
					dv_low_s[k+1][i] <= dv_low_s[k][i] << 1;
					dv_q_s[k+1][i] <= {dv_q_s[k][i][W-2:0], ge_n[k][i]};
					dv_neg_s[k+1][i] <= dv_neg_s[k][i];
					dv_big_s[k+1][i] <= dv_big_s[k][i];
				end
			end

			for (int i = 0; i < N_ELEM; i++) inv_q[i] <= val_n[i];
			det_q <= dv_det_s[W];
			sing_q <= dv_sing_s[W];
			ovf_q <= ovf_n;
		end
	end

	assign m_tvalid = vo_q;
	assign m_tuser = {ovf_q, sing_q};
	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < N_ELEM; i++) m_tdata[i*W +: W] = inv_q[i];
		m_tdata[N_ELEM*W +: W] = det_q;
	end

	`MI3_ASSERT_IMP(a_sing_clear, clk, arst_n, m_tvalid && m_tuser[0], !m_tuser[1] && (m_tdata[N_ELEM*W-1:0] == '0))
	`MI3_ASSERT_IMP(a_pop_valid, clk, arst_n, q_pop, q_valid)
	`MI3_ASSERT_IMP(a_out_hold, clk, arst_n, $past(m_tvalid && !m_tready), m_tvalid)
endmodule
`default_nettype wire

>>> src/matrix3_inverse.sv
// 3x3 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// input channel s_*: one matrix per item, nine elements row by row.
// output channel m_*: nine inverse elements row by row, then the determinant;
// m_tuser flags a singular matrix and any saturated output value.
// the front pipeline forms the cofactors and the exact determinant and
// writes them into an 8-entry queue; the back pipeline takes
// the absolute values, runs nine restoring dividers in parallel with one
// quotient bit per stage, and saturates into the output register.
// one item is accepted per cycle while m_tready stays high, since the
// divider stages each take a new item every cycle.
// when m_tready is low the back pipeline holds while the queue fills, and
// s_tready drops once the queue and front stages hold 8 items in total.
// reset empties the queue and all stages; no result is pending afterwards.
`default_nettype none
module matrix3_inverse import mi3_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// elem_r0c0, elem_r0c1, .. elem_r2c2, zero pad
	input  logic [((N_ELEM*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// inv_r0c0, inv_r0c1, .. inv_r2c2, determinant, zero pad
	output logic [((10*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// singular, overflow
	output logic [1:0] m_tuser
);
	localparam int CW = 2*DATA_WIDTH + 1;
	localparam int DW = 3*DATA_WIDTH + 3;
	localparam int QW = N_ELEM*CW + DW;

	logic f_push, b_pop, q_ne;
	logic [N_ELEM*CW-1:0] f_cof;
	logic [DW-1:0] f_det;
	logic [QW-1:0] q_rd;
	q_evt_t evt;

	assign evt.push = f_push;
	assign evt.pop = b_pop;

	mi3_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.q_pop(b_pop), .push(f_push), .cof(f_cof), .det(f_det)
	);

	mi3_queue #(.DATA_W(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .evt(evt),
		.wdata({f_det, f_cof}), .rdata(q_rd), .not_empty(q_ne)
	);

	mi3_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_ne), .q_cof(q_rd[N_ELEM*CW-1:0]), .q_det(q_rd[QW-1:N_ELEM*CW]),
		.q_pop(b_pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);
endmodule
`default_nettype wire

>>> verif/matrix3_inverse_tb.sv
`timescale 1ns / 1ps
module matrix3_inverse_tb;
	import mi3_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam int WD_LIMIT = 5000;
	localparam int LONG_HOLD = 300;

	typedef logic signed [127:0] wide_t;
	typedef struct {
		logic [10*DW-1:0] data;
		logic [1:0] flags;
	} inv_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [N_ELEM*DW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [10*DW-1:0] m_tdata;
	logic [1:0] m_tuser;

	inv_result_t expected_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;
	int hold_cycles = 0;
	int hold_reqs = 0;
	int hold_done = 0;

	always #1 clk = ~clk;

	matrix3_inverse #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	function automatic logic [DW-1:0] clamp(input wide_t v, inout bit ovf);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (DW - 1)) - 1;
		lo = -(wide_t'(1) <<< (DW - 1));
		if (v > hi) begin
			ovf = 1'b1;
			return hi[DW-1:0];
		end
		if (v < lo) begin
			ovf = 1'b1;
			return lo[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	function automatic inv_result_t invert(input logic [N_ELEM*DW-1:0] m);
		wide_t e[9], cf[9], det;
		bit ovf;
		inv_result_t x;
		ovf = 1'b0;
		for (int i = 0; i < 9; i++) e[i] = $signed(m[i*DW +: DW]);
		cf[0] = e[4] * e[8] - e[5] * e[7];
		cf[1] = e[5] * e[6] - e[3] * e[8];
		cf[2] = e[3] * e[7] - e[4] * e[6];
		cf[3] = e[2] * e[7] - e[1] * e[8];
		cf[4] = e[0] * e[8] - e[2] * e[6];
		cf[5] = e[1] * e[6] - e[0] * e[7];
		cf[6] = e[1] * e[5] - e[2] * e[4];
		cf[7] = e[2] * e[3] - e[0] * e[5];
		cf[8] = e[0] * e[4] - e[1] * e[3];
		det = e[0] * cf[0] + e[1] * cf[1] + e[2] * cf[2];
		x.data = '0;
		x.data[9*DW +: DW] = clamp(det >>> (2 * FB), ovf);
		if (det != 0) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					x.data[(r*3+c)*DW +: DW] = clamp((cf[c*3+r] <<< (2 * FB)) / det, ovf);
		end
		x.flags = {ovf, det == 0};
		return x;
	endfunction

	task automatic report(input string what, input logic [DW-1:0] got, input logic [DW-1:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		inv_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				report("unexpected item", m_tdata[DW-1:0], '0);
			end else begin
				want = expected_q.pop_front();
				for (int i = 0; i < 10; i++)
					if (m_tdata[i*DW +: DW] !== want.data[i*DW +: DW])
						report($sformatf("field %0d", i), m_tdata[i*DW +: DW],
							want.data[i*DW +: DW]);
				if (m_tuser[0] !== want.flags[0])
					report("singular", DW'(m_tuser[0]), DW'(want.flags[0]));
				if (m_tuser[1] !== want.flags[1])
					report("overflow", DW'(m_tuser[1]), DW'(want.flags[1]));
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver side stalls
	always @(negedge clk) begin
		int burst;
		if (arst_n) begin
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else if (hold_done != hold_reqs) begin
				// long hold requested by a test
				m_tready <= 1'b0;
				hold_cycles <= LONG_HOLD - 1;
				hold_done <= hold_reqs;
			end else if (gaps_on && !m_tready) begin
				m_tready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 4);
				m_tready <= 1'b0;
				hold_cycles <= burst - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_matrix(input logic [N_ELEM*DW-1:0] m);
		int gap;
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= m;
		do @(posedge clk); while (!s_tready);
		expected_q.push_back(invert(m));
		@(negedge clk);
	endtask

	function automatic logic [N_ELEM*DW-1:0] diag(input logic [DW-1:0] a, b, c);
		logic [N_ELEM*DW-1:0] m;
		m = '0;
		m[0 +: DW] = a;
		m[4*DW +: DW] = b;
		m[8*DW +: DW] = c;
		return m;
	endfunction

	function automatic logic [N_ELEM*DW-1:0] random_matrix();
		logic [N_ELEM*DW-1:0] m;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 9; i++) begin
			case (kind)
				0, 1, 2: m[i*DW +: DW] = $urandom();
				// a few units in magnitude
				3, 4, 5, 6: m[i*DW +: DW] = $signed($urandom_range(0, 32'h0008_0000))
					- 32'sh0004_0000;
				7: m[i*DW +: DW] = $signed($urandom_range(0, 255)) - 128;
				default: m[i*DW +: DW] = (i % 4 == 0) ? 32'h0001_0000 + $urandom_range(0, 4095)
					: $urandom_range(0, 4095);
			endcase
		end
		// singular: row 2 duplicates row 0
		if ($urandom_range(0, 7) == 0) m[6*DW +: 3*DW] = m[0 +: 3*DW];
		return m;
	endfunction

	task automatic drain(input int tail);
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic test_directed();
		logic [N_ELEM*DW-1:0] m;
		send_matrix('0);
		send_matrix(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
		send_matrix(diag(32'hffff_0000, 32'hffff_0000, 32'hffff_0000));
		send_matrix(diag(32'h0002_0000, 32'h0000_8000, 32'hfffc_0000));
		// tiny determinant, inverse saturates
		send_matrix(diag(32'd1, 32'd1, 32'd1));
		// determinant saturates
		send_matrix(diag(32'h7fff_0000, 32'h7fff_0000, 32'h7fff_0000));
		send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_matrix({N_ELEM{32'h7fff_ffff}});
		send_matrix({N_ELEM{32'h8000_0000}});
		for (int i = 0; i < 9; i++) m[i*DW +: DW] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
		send_matrix(m);
		m = diag(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		m[2*DW +: DW] = 32'h8000_0000;
		m[6*DW +: DW] = 32'h7fff_ffff;
		send_matrix(m);
		for (int i = 0; i < 9; i++) m[i*DW +: DW] = (i + 1) << FB;
		send_matrix(m);
		m[8*DW +: DW] = 32'h000a_0000;
		send_matrix(m);
		send_matrix({N_ELEM{32'hffff_ffff}});
		send_matrix(diag(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff));
		drain(50);
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) send_matrix(random_matrix());
		drain(50);
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_reqs++;
		for (int i = 0; i < 40; i++) send_matrix(random_matrix());
		drain(50);
	endtask

	task automatic test_streaming(input int count);
		gaps_on = 1'b0;
		for (int i = 0; i < count; i++) send_matrix(random_matrix());
		drain(60);
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1100);
		test_backpressure();
		test_streaming(400);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

>>> matrix3_inverse.f
+incdir+src
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_queue.sv
src/mi3_back.sv
src/matrix3_inverse.sv
verif/matrix3_inverse_tb.sv
